// ----- rtl/pps_pkg.sv -----
// shared types, constants and helper functions for the palette parity embedder
// no dependencies; used by every rtl file through scoped names
package pps_pkg;

   localparam int PaletteEntriesDefault = 256;
   localparam int ColorWidth = 8;
   localparam int RgbWidth = 3 * ColorWidth;
   localparam int IndexWidth = 8;
   localparam int SquareWidth = 2 * ColorWidth;
   localparam int DistWidth = SquareWidth + 2;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_EMBED = 2'd1;
   localparam logic [1:0] MODE_EXTRACT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HERE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } pps_state_type;

   typedef struct packed {
      logic busy;
      logic found;
   } scan_status_type;

   // parity of r+g+b is the xor of the three low bits
   function automatic logic rgb_parity(input logic [RgbWidth-1:0] rgb);
      rgb_parity = rgb[2*ColorWidth] ^ rgb[ColorWidth] ^ rgb[0];
   endfunction

   function automatic logic [ColorWidth-1:0] abs_diff(input logic [ColorWidth-1:0] a,
                                                      input logic [ColorWidth-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- rtl/pps_palette_mem.sv -----
// palette storage: one write port, one read port with registered read data
// depends on pps_pkg for the entry width
module pps_palette_mem #(
   parameter int DEPTH = pps_pkg::PaletteEntriesDefault,
   parameter int ADDR_W = $clog2(pps_pkg::PaletteEntriesDefault)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [pps_pkg::RgbWidth-1:0]  wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [pps_pkg::RgbWidth-1:0]  rd_data
);

   logic [pps_pkg::RgbWidth-1:0] mem [DEPTH];
   logic [pps_pkg::RgbWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pps_scan.sv -----
// two-stage distance unit: squared channel differences, then sum, compare
// and keep the nearest candidate of the wanted parity; depends on pps_pkg
module pps_scan #(
   parameter int IDX_W = $clog2(pps_pkg::PaletteEntriesDefault)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  logic                            cand_valid,
   input  logic [IDX_W-1:0]                cand_index,
   input  logic [pps_pkg::RgbWidth-1:0]    cand_rgb,
   input  logic [pps_pkg::RgbWidth-1:0]    here_rgb,
   input  logic                            want_bit,
   output pps_pkg::scan_status_type        status,
   output logic [IDX_W-1:0]                best_index
);

   localparam int CW = pps_pkg::ColorWidth;
   localparam int SW = pps_pkg::SquareWidth;
   localparam int DW = pps_pkg::DistWidth;

   logic [CW-1:0] diff_r, diff_g, diff_b;
   logic [SW-1:0] sq_r_in, sq_g_in, sq_b_in;
   logic [SW-1:0] sq_r_ff, sq_g_ff, sq_b_ff;
   logic          match_in;
   logic          s1_valid_ff, s1_match_ff;
   logic [IDX_W-1:0] s1_index_ff;
   logic [DW-1:0] cand_dist;
   logic          take;
   logic          found_ff, found_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic [DW-1:0] best_dist_ff, best_dist_in;

   // stage one: per-channel squares
   always_comb begin
      diff_r = pps_pkg::abs_diff(cand_rgb[3*CW-1:2*CW], here_rgb[3*CW-1:2*CW]);
      diff_g = pps_pkg::abs_diff(cand_rgb[2*CW-1:CW], here_rgb[2*CW-1:CW]);
      diff_b = pps_pkg::abs_diff(cand_rgb[CW-1:0], here_rgb[CW-1:0]);
      sq_r_in = SW'(diff_r) * SW'(diff_r);
      sq_g_in = SW'(diff_g) * SW'(diff_g);
      sq_b_in = SW'(diff_b) * SW'(diff_b);
      match_in = (pps_pkg::rgb_parity(cand_rgb) == want_bit);
   end

   // stage two: strict less-than keeps the lowest index on ties
   always_comb begin
      cand_dist = DW'(sq_r_ff) + DW'(sq_g_ff) + DW'(sq_b_ff);
      take = s1_valid_ff && s1_match_ff && (!found_ff || (cand_dist < best_dist_ff));
      found_in = found_ff;
      best_in = best_ff;
      best_dist_in = best_dist_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         best_in = s1_index_ff;
         best_dist_in = cand_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cand_valid;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_r_ff <= sq_r_in;
      sq_g_ff <= sq_g_in;
      sq_b_ff <= sq_b_in;
      s1_match_ff <= match_in;
      s1_index_ff <= cand_index;
      best_ff <= best_in;
      best_dist_ff <= best_dist_in;
   end

   assign status.busy = s1_valid_ff;
   assign status.found = found_ff;
   assign best_index = best_ff;

endmodule

// ----- rtl/palette_parity_stego_embedder_top.sv -----
// Palette parity embedder. One input channel (req_*) carries load, embed and
// extract items; one result channel (rsp_*) returns one result per item.
// A load writes one palette entry and answers with the entry's parity.
// An extract reads the indexed entry and answers with its parity.
// An embed reads the pixel's entry, then streams every palette entry out of
// the palette memory's read port (one entry per cycle) through a two-stage
// distance unit that keeps the nearest entry of the wanted parity, lowest
// index on ties; if none has that parity, no_match is set and the index kept.
// The palette scan makes one memory read per cycle. One item is in flight at
// a time: a new item is taken only once the result of the last one has
// been formed and moved into the output register.
// The result sits in an output register: a stalled receiver does not block
// the next input transfer, but the following result waits until it is free.
// Reset clears the control state and the output valid; palette contents are
// not cleared, and every entry must be loaded before the first embed.
// Depends on pps_pkg, pps_palette_mem and pps_scan.
module palette_parity_stego_embedder_top #(
   parameter int PALETTE_ENTRIES = pps_pkg::PaletteEntriesDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [pps_pkg::IndexWidth-1:0]    req_pixel_index,
   input  logic [pps_pkg::ColorWidth-1:0]    req_red,
   input  logic [pps_pkg::ColorWidth-1:0]    req_green,
   input  logic [pps_pkg::ColorWidth-1:0]    req_blue,
   input  logic                              req_message_bit,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pps_pkg::IndexWidth-1:0]    rsp_new_index,
   output logic                              rsp_parity_bit,
   output logic                              rsp_no_match
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam int XW = pps_pkg::IndexWidth;

   pps_pkg::pps_state_type state_ff, state_in;

   logic [1:0]    mode_ff, mode_in;
   logic [XW-1:0] idx_ff, idx_in;
   logic          in_range_ff, in_range_in;
   logic          bit_ff, bit_in;
   logic [pps_pkg::RgbWidth-1:0] here_ff, here_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic          cand_valid_ff, cand_valid_in;
   logic [IDX_W-1:0] cand_index_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0] rsp_index_ff, rsp_index_in;
   logic          rsp_parity_ff, rsp_parity_in;
   logic          rsp_nomatch_ff, rsp_nomatch_in;

   logic          accept;
   logic          req_in_range;
   logic          out_free;
   logic          scan_last;
   logic          mem_wr_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [pps_pkg::RgbWidth-1:0] mem_rd_data;
   logic          scan_clear;
   logic          scan_issue;
   logic          load_result;

   pps_pkg::scan_status_type scan_status;
   logic [IDX_W-1:0] best_index;

   assign accept = req_valid && req_ready;
   assign req_in_range = ({1'b0, req_pixel_index} < (XW+1)'(PALETTE_ENTRIES));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign scan_last = (cnt_ff == IDX_W'(PALETTE_ENTRIES - 1));

   pps_palette_mem #(
      .DEPTH  (PALETTE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_palette_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (req_pixel_index[IDX_W-1:0]),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pps_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_clear),
      .cand_valid (cand_valid_ff),
      .cand_index (cand_index_ff),
      .cand_rgb   (mem_rd_data),
      .here_rgb   (here_ff),
      .want_bit   (bit_ff),
      .status     (scan_status),
      .best_index (best_index)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == pps_pkg::MODE_EMBED || req_mode == pps_pkg::MODE_EXTRACT) begin
                  state_in = pps_pkg::ST_HERE;
               end else begin
                  state_in = pps_pkg::ST_DONE;
               end
            end
         end
         pps_pkg::ST_HERE: begin
            if (mode_ff == pps_pkg::MODE_EMBED) begin
               state_in = pps_pkg::ST_SCAN;
            end else begin
               state_in = pps_pkg::ST_DONE;
            end
         end
         pps_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = pps_pkg::ST_DRAIN;
            end
         end
         pps_pkg::ST_DRAIN: begin
            if (!cand_valid_ff && !scan_status.busy) begin
               state_in = pps_pkg::ST_DONE;
            end
         end
         pps_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = pps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pps_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      mem_wr_en = 1'b0;
      mem_rd_addr = req_pixel_index[IDX_W-1:0];
      scan_clear = 1'b0;
      scan_issue = 1'b0;
      load_result = 1'b0;
      case (state_ff)
         pps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mem_wr_en = accept && (req_mode == pps_pkg::MODE_LOAD) && req_in_range;
         end
         pps_pkg::ST_HERE: begin
            scan_clear = 1'b1;
         end
         pps_pkg::ST_SCAN: begin
            mem_rd_addr = cnt_ff;
            scan_issue = 1'b1;
         end
         pps_pkg::ST_DRAIN: begin
         end
         pps_pkg::ST_DONE: begin
            load_result = out_free;
         end
         default: begin
         end
      endcase
   end

   // item registers and scan counter
   always_comb begin
      mode_in = mode_ff;
      idx_in = idx_ff;
      in_range_in = in_range_ff;
      bit_in = bit_ff;
      here_in = here_ff;
      cnt_in = cnt_ff;
      cand_valid_in = scan_issue;
      if (accept) begin
         mode_in = req_mode;
         idx_in = req_pixel_index;
         in_range_in = req_in_range;
         bit_in = req_message_bit;
         here_in = {req_red, req_green, req_blue};
      end
      if (state_ff == pps_pkg::ST_HERE) begin
         // out-of-range pixels search from black
         here_in = in_range_ff ? mem_rd_data : '0;
         cnt_in = '0;
      end
      if (scan_issue) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
   end

   // result formation
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_parity_in = rsp_parity_ff;
      rsp_nomatch_in = rsp_nomatch_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_result) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = idx_ff;
         rsp_parity_in = 1'b0;
         rsp_nomatch_in = 1'b0;
         case (mode_ff)
            pps_pkg::MODE_LOAD: begin
               rsp_parity_in = in_range_ff && pps_pkg::rgb_parity(here_ff);
            end
            pps_pkg::MODE_EMBED: begin
               if (scan_status.found) begin
                  rsp_index_in = XW'(best_index);
                  rsp_parity_in = bit_ff;
               end else begin
                  rsp_parity_in = pps_pkg::rgb_parity(here_ff);
                  rsp_nomatch_in = 1'b1;
               end
            end
            pps_pkg::MODE_EXTRACT: begin
               rsp_parity_in = pps_pkg::rgb_parity(here_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cand_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cand_valid_ff <= cand_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      idx_ff <= idx_in;
      in_range_ff <= in_range_in;
      bit_ff <= bit_in;
      here_ff <= here_in;
      cnt_ff <= cnt_in;
      cand_index_ff <= cnt_ff;
      rsp_index_ff <= rsp_index_in;
      rsp_parity_ff <= rsp_parity_in;
      rsp_nomatch_ff <= rsp_nomatch_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_new_index = rsp_index_ff;
   assign rsp_parity_bit = rsp_parity_ff;
   assign rsp_no_match = rsp_nomatch_ff;

endmodule

// ----- rtl/pps_checker.sv -----
// port-level checker for the palette parity embedder, bound to the top level
// depends on pps_pkg for field widths
module pps_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pps_pkg::IndexWidth-1:0] rsp_new_index,
   input logic                           rsp_parity_bit,
   input logic                           rsp_no_match
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_index)
         && $stable(rsp_parity_bit) && $stable(rsp_no_match))
      else $error("stalled result changed");

   // one item in flight: no transfer right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in flight");

   // a new result appears only while the input side was closed
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised without work in flight");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind palette_parity_stego_embedder_top pps_checker u_pps_checker (.*);

// ----- bench/tb_palette_parity_stego_embedder_top.sv -----
// self-checking bench for palette_parity_stego_embedder_top: loads, embeds, extracts
// predicts each result from a private palette copy; depends on pps_pkg and the rtl
`timescale 1ns / 1ps

module tb_palette_parity_stego_embedder_top;

   localparam int PaletteEntries = 256;
   localparam logic [1:0] ModeUnused = 2'd3;
   localparam int ColorW = pps_pkg::ColorWidth;
   localparam int IndexW = pps_pkg::IndexWidth;

   typedef struct packed {
      logic [IndexW-1:0] new_index;
      logic              parity_bit;
      logic              no_match;
   } stego_answer_type;

   typedef enum {FILL_RANDOM, FILL_TIES, FILL_EVEN, FILL_ODD} fill_kind_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_mode = pps_pkg::MODE_LOAD;
   logic [IndexW-1:0] req_pixel_index = '0;
   logic [ColorW-1:0] req_red = '0;
   logic [ColorW-1:0] req_green = '0;
   logic [ColorW-1:0] req_blue = '0;
   logic              req_message_bit = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [IndexW-1:0] rsp_new_index;
   logic              rsp_parity_bit;
   logic              rsp_no_match;

   // private copy of the palette, r in the top byte
   logic [3*ColorW-1:0] palette_copy [PaletteEntries];
   stego_answer_type    stego_answers [$];
   stego_answer_type    oldest;
   int                  error_count = 0;
   int                  req_idle_pct = 0;
   int                  rsp_idle_pct = 0;

   palette_parity_stego_embedder_top #(
      .PALETTE_ENTRIES(PaletteEntries)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_message_bit (req_message_bit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_new_index   (rsp_new_index),
      .rsp_parity_bit  (rsp_parity_bit),
      .rsp_no_match    (rsp_no_match)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("palette_parity_stego_embedder_top regression: fail");
      $finish;
   end

   function automatic logic [3*ColorW-1:0] palette_entry(input int idx);
      return (idx < PaletteEntries) ? palette_copy[idx] : '0;
   endfunction

   function automatic logic rgb_odd(input logic [3*ColorW-1:0] rgb);
      int sum;
      sum = rgb[23:16] + rgb[15:8] + rgb[7:0];
      return sum[0];
   endfunction

   function automatic int color_distance(input logic [3*ColorW-1:0] x,
                                         input logic [3*ColorW-1:0] y);
      int dr;
      int dg;
      int db;
      dr = int'(x[23:16]) - int'(y[23:16]);
      dg = int'(x[15:8]) - int'(y[15:8]);
      db = int'(x[7:0]) - int'(y[7:0]);
      return dr * dr + dg * dg + db * db;
   endfunction

   // result of one item; a load also updates the palette copy
   function automatic stego_answer_type stego_answer(input logic [1:0] mode,
                                                     input logic [IndexW-1:0] idx,
                                                     input logic [ColorW-1:0] r,
                                                     input logic [ColorW-1:0] g,
                                                     input logic [ColorW-1:0] b,
                                                     input logic msg_bit);
      stego_answer_type    ans;
      logic [3*ColorW-1:0] here;
      logic [3*ColorW-1:0] cand;
      logic                found;
      int                  best_dist;
      int                  d;
      ans = '{new_index: idx, parity_bit: 1'b0, no_match: 1'b0};
      case (mode)
         pps_pkg::MODE_LOAD: begin
            if (idx < PaletteEntries) begin
               palette_copy[idx] = {r, g, b};
               ans.parity_bit = rgb_odd({r, g, b});
            end
         end
         pps_pkg::MODE_EMBED: begin
            here = palette_entry(idx);
            found = 1'b0;
            best_dist = 0;
            for (int i = 0; i < PaletteEntries; i++) begin
               cand = palette_entry(i);
               if (rgb_odd(cand) == msg_bit) begin
                  d = color_distance(here, cand);
                  // strict compare keeps the lowest index on ties
                  if (!found || d < best_dist) begin
                     found = 1'b1;
                     best_dist = d;
                     ans.new_index = i[IndexW-1:0];
                  end
               end
            end
            if (found) begin
               ans.parity_bit = msg_bit;
            end else begin
               ans.parity_bit = rgb_odd(here);
               ans.no_match = 1'b1;
            end
         end
         pps_pkg::MODE_EXTRACT: begin
            ans.parity_bit = rgb_odd(palette_entry(idx));
         end
         default: ;
      endcase
      return ans;
   endfunction

   // result channel: check each transfer, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (stego_answers.size() == 0) begin
            $display("%0t: rsp transfer with nothing expected: expected none, actual index %0d",
                     $time, rsp_new_index);
            error_count++;
         end else begin
            oldest = stego_answers.pop_front();
            if (rsp_new_index !== oldest.new_index) begin
               $display("%0t: new_index mismatch: expected %0d actual %0d",
                        $time, oldest.new_index, rsp_new_index);
               error_count++;
            end
            if (rsp_parity_bit !== oldest.parity_bit) begin
               $display("%0t: parity_bit mismatch: expected %0d actual %0d",
                        $time, oldest.parity_bit, rsp_parity_bit);
               error_count++;
            end
            if (rsp_no_match !== oldest.no_match) begin
               $display("%0t: no_match mismatch: expected %0d actual %0d",
                        $time, oldest.no_match, rsp_no_match);
               error_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic send_item(input logic [1:0] mode, input logic [IndexW-1:0] idx,
                            input logic [ColorW-1:0] r, input logic [ColorW-1:0] g,
                            input logic [ColorW-1:0] b, input logic msg_bit);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_pixel_index <= idx;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_message_bit <= msg_bit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      stego_answers.push_back(stego_answer(mode, idx, r, g, b, msg_bit));
   endtask

   function automatic logic [ColorW-1:0] corner_channel();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd128;
         default: return 8'd255;
      endcase
   endfunction

   function automatic logic [ColorW-1:0] any_channel();
      return ($urandom_range(9) < 3) ? corner_channel() : ColorW'($urandom_range(255));
   endfunction

   task automatic fill_palette(input fill_kind_type kind);
      logic [ColorW-1:0] r;
      logic [ColorW-1:0] g;
      logic [ColorW-1:0] b;
      for (int i = 0; i < PaletteEntries; i++) begin
         if (kind == FILL_TIES) begin
            r = corner_channel();
            g = corner_channel();
            b = corner_channel();
         end else begin
            r = ColorW'($urandom_range(255));
            g = ColorW'($urandom_range(255));
            b = ColorW'($urandom_range(255));
         end
         // force a single parity across the whole palette
         if (kind == FILL_EVEN || kind == FILL_ODD) begin
            b[0] = r[0] ^ g[0] ^ (kind == FILL_ODD);
         end
         send_item(pps_pkg::MODE_LOAD, i[IndexW-1:0], r, g, b, 1'($urandom_range(1)));
      end
   endtask

   task automatic wait_for_answers();
      do @(posedge clock); while (stego_answers.size() != 0);
   endtask

   // loads at the field extremes, read back, unused mode
   task automatic test_load_extract();
      send_item(pps_pkg::MODE_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(pps_pkg::MODE_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_item(pps_pkg::MODE_LOAD, 8'd128, 8'd255, 8'd0, 8'd0, 1'b0);
      send_item(pps_pkg::MODE_LOAD, 8'd85, 8'd170, 8'd85, 8'd254, 1'b1);
      send_item(pps_pkg::MODE_EXTRACT, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
      send_item(pps_pkg::MODE_EXTRACT, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
      send_item(pps_pkg::MODE_EXTRACT, 8'd128, 8'd0, 8'd0, 8'd0, 1'b0);
      send_item(pps_pkg::MODE_EXTRACT, 8'd85, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(ModeUnused, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_item(ModeUnused, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
   endtask

   // nearest search, own entry, duplicate colors resolved to the lower index
   task automatic test_embed();
      send_item(pps_pkg::MODE_LOAD, 8'd9, 8'd1, 8'd0, 8'd0, 1'b0);
      send_item(pps_pkg::MODE_LOAD, 8'd5, 8'd1, 8'd0, 8'd0, 1'b0);
      send_item(pps_pkg::MODE_LOAD, 8'd200, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(pps_pkg::MODE_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(pps_pkg::MODE_EMBED, 8'd9, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(pps_pkg::MODE_EMBED, 8'd9, 8'd0, 8'd0, 8'd0, 1'b0);
      send_item(pps_pkg::MODE_EMBED, 8'd200, 8'd255, 8'd255, 8'd255, 1'b0);
      send_item(pps_pkg::MODE_EMBED, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(pps_pkg::MODE_EMBED, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(pps_pkg::MODE_EMBED, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
      send_item(pps_pkg::MODE_EXTRACT, 8'd5, 8'd0, 8'd0, 8'd0, 1'b0);
   endtask

   // single-parity palettes: asking for the other parity finds nothing
   task automatic test_no_match();
      fill_palette(FILL_EVEN);
      send_item(pps_pkg::MODE_EMBED, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(pps_pkg::MODE_EMBED, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(pps_pkg::MODE_EMBED, 8'd77, 8'd0, 8'd0, 8'd0, 1'b0);
      fill_palette(FILL_ODD);
      send_item(pps_pkg::MODE_EMBED, 8'd3, 8'd0, 8'd0, 8'd0, 1'b0);
      send_item(pps_pkg::MODE_EMBED, 8'd3, 8'd0, 8'd0, 8'd0, 1'b1);
   endtask

   // palette fully loaded beforehand, so any index may be read
   task automatic test_random_traffic(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_item(pps_pkg::MODE_LOAD, IndexW'($urandom_range(255)), any_channel(),
                      any_channel(), any_channel(), 1'($urandom_range(1)));
         end else if (pick < 65) begin
            send_item(pps_pkg::MODE_EMBED, IndexW'($urandom_range(255)),
                      ColorW'($urandom_range(255)), ColorW'($urandom_range(255)),
                      ColorW'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (pick < 95) begin
            send_item(pps_pkg::MODE_EXTRACT, IndexW'($urandom_range(255)),
                      ColorW'($urandom_range(255)), ColorW'($urandom_range(255)),
                      ColorW'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            send_item(ModeUnused, IndexW'($urandom_range(255)),
                      ColorW'($urandom_range(255)), ColorW'($urandom_range(255)),
                      ColorW'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      req_idle_pct = 21;
      rsp_idle_pct = 86;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_load_extract();
      fill_palette(FILL_RANDOM);
      test_embed();
      test_no_match();
      fill_palette(FILL_RANDOM);
      test_random_traffic(165);
      req_idle_pct = 86;
      rsp_idle_pct = 21;
      fill_palette(FILL_TIES);
      test_random_traffic(165);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      fill_palette(FILL_EVEN);
      test_random_traffic(165);
      req_valid <= 1'b0;
      wait_for_answers();
      repeat (PaletteEntries + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("palette_parity_stego_embedder_top regression: pass");
      end else begin
         $display("palette_parity_stego_embedder_top regression: fail");
      end
      $finish;
   end

endmodule
